// ===== hdl/rrme_pkg.sv =====
// Package for the register and memory execute unit.
// Holds sizes, the opcode and load-kind types, and the shift and compare helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrme_pkg;

  localparam int unsigned NUM_REGS       = 32;
  localparam int unsigned MEM_BYTES      = 65536;
  localparam int unsigned OP_W           = 5;
  localparam int unsigned REG_IDX_W      = 5;
  localparam int unsigned IMM_W          = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned MEM_ADDR_OUT_W = 16;
  localparam int unsigned RF_AW          = $clog2(NUM_REGS);
  localparam int unsigned MEM_AW         = $clog2(MEM_BYTES);
  localparam int unsigned NUM_BANKS      = DATA_W / BYTE_W;
  localparam int unsigned BANK_SEL_W     = $clog2(NUM_BANKS);
  localparam int unsigned ROW_W          = MEM_AW - BANK_SEL_W;
  localparam int unsigned BANK_ROWS      = MEM_BYTES / NUM_BANKS;
  localparam int unsigned SHAMT_W        = $clog2(DATA_W);

  typedef enum logic [OP_W-1:0] {
    OP_NOP = 5'd0,
    OP_ADD = 5'd1,
    OP_SUB = 5'd2,
    OP_AND = 5'd3,
    OP_OR  = 5'd4,
    OP_XOR = 5'd5,
    OP_NOT = 5'd6,
    OP_LSH = 5'd7,
    OP_ASH = 5'd8,
    OP_TCU = 5'd9,
    OP_TCS = 5'd10,
    OP_SET = 5'd11,
    OP_MOV = 5'd12,
    OP_LDW = 5'd13,
    OP_STW = 5'd14,
    OP_LDB = 5'd15,
    OP_STB = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_WORD,
    LD_BYTE
  } load_e;

  function automatic logic reg_in_range(input logic [REG_IDX_W-1:0] idx);
    return {1'b0, idx} < (REG_IDX_W + 1)'(NUM_REGS);
  endfunction

  // A negative count shifts right by its magnitude; a magnitude of the word
  // width or more gives zero, or the sign fill for an arithmetic right shift.
  function automatic logic [DATA_W-1:0] shift_val(input logic [DATA_W-1:0] v,
                                                  input logic [DATA_W-1:0] cnt,
                                                  input logic              arith);
    logic [DATA_W-1:0] fill;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] res;
    fill = (arith && v[DATA_W-1]) ? '1 : '0;
    mag  = ~cnt + DATA_W'(1);
    if (!cnt[DATA_W-1]) begin
      res = (|cnt[DATA_W-1:SHAMT_W]) ? '0 : (v << cnt[SHAMT_W-1:0]);
    end else if (|mag[DATA_W-1:SHAMT_W]) begin
      res = fill;
    end else if (arith) begin
      res = $unsigned($signed(v) >>> mag[SHAMT_W-1:0]);
    end else begin
      res = v >> mag[SHAMT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] cmp3(input logic [DATA_W-1:0] b,
                                             input logic [DATA_W-1:0] c,
                                             input logic              sgn);
    logic [DATA_W-1:0] bx;
    logic [DATA_W-1:0] cx;
    logic [DATA_W-1:0] res;
    bx = b;
    cx = c;
    if (sgn) begin
      bx[DATA_W-1] = ~b[DATA_W-1];
      cx[DATA_W-1] = ~c[DATA_W-1];
    end
    if (bx > cx) begin
      res = DATA_W'(1);
    end else if (bx < cx) begin
      res = '1;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/risc_register_memory_execute.sv =====
// Execute unit of a small 32-bit register machine: register file, ALU and a
// four-bank byte memory in one three-register pipeline.
// Depends on rrme_pkg.
//
// Usage: an instruction request enters on in_valid_i/in_ready_o with its
// opcode, three register fields and an immediate. One result request per
// instruction leaves on out_valid_o/out_ready_i, in instruction order.
// The register file is read when a request is taken; the first stage runs
// the ALU and issues the memory access to four byte-wide banks, the second
// stage assembles load data and writes the register file as the result
// moves into the output register. Results in the second stage are
// forwarded, so dependent instructions can follow each other directly.
// Throughput: one instruction per cycle while the receiver does not stall;
// the single port of each memory bank and the one write port of the
// register file set that limit.
// When the receiver stalls, each stage still fills up, and the input takes a
// new request until all three stages hold results.
// Reset empties the pipeline and marks all registers as zero. Memory has
// no reset and no clearing pass; a load of a never-stored byte is undefined.
`timescale 1ns / 1ps
`default_nettype none

module risc_register_memory_execute (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [rrme_pkg::OP_W-1:0]            req_type_i,
  input  wire logic [rrme_pkg::REG_IDX_W-1:0]       reg_a_i,
  input  wire logic [rrme_pkg::REG_IDX_W-1:0]       reg_b_i,
  input  wire logic [rrme_pkg::REG_IDX_W-1:0]       reg_c_i,
  input  wire logic [rrme_pkg::IMM_W-1:0]           immediate_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      reg_written_o,
  output logic [rrme_pkg::REG_IDX_W-1:0]            reg_index_o,
  output logic [rrme_pkg::DATA_W-1:0]               reg_value_o,
  output logic                                      mem_written_o,
  output logic [rrme_pkg::MEM_ADDR_OUT_W-1:0]       mem_address_o,
  output logic                                      bad_opcode_o
);

  import rrme_pkg::*;

  logic                   in_acc;
  logic                   out_free;
  logic                   s2_free;
  logic                   s1_adv;
  logic                   s2_adv;
  logic [REG_IDX_W-1:0]   in_p1;

  logic                   s1_v_q;
  logic                   s2_v_q;
  logic                   out_v_q;
  logic [NUM_REGS-1:0]    rf_vld_q;

  logic [OP_W-1:0]        s1_op_q;
  logic [REG_IDX_W-1:0]   s1_a_q;
  logic [REG_IDX_W-1:0]   s1_c_q;
  logic [REG_IDX_W-1:0]   s1_p1_q;
  logic [REG_IDX_W-1:0]   s1_p2_q;
  logic [IMM_W-1:0]       s1_imm_q;
  logic [DATA_W-1:0]      rd1_q;
  logic [DATA_W-1:0]      rd2_q;

  logic [DATA_W-1:0]      rf_mem [NUM_REGS];
  logic                   rf_we;
  logic [RF_AW-1:0]       rf_wa;
  logic [DATA_W-1:0]      rf_wd;
  logic [RF_AW-1:0]       p1_ra;
  logic [RF_AW-1:0]       p2_ra;

  logic [DATA_W-1:0]      op1;
  logic [DATA_W-1:0]      op2;
  logic                   s1_wr;
  logic [REG_IDX_W-1:0]   s1_dst;
  logic [DATA_W-1:0]      s1_alu;
  load_e                  s1_ld;
  logic                   s1_st;
  logic                   s1_mem;
  logic                   s1_word;
  logic [MEM_AW-1:0]      s1_addr;
  logic                   s1_bad;
  logic [NUM_BANKS-1:0]   bank_we;
  logic [ROW_W-1:0]       bank_row   [NUM_BANKS];
  logic [BYTE_W-1:0]      bank_wd    [NUM_BANKS];
  logic [BYTE_W-1:0]      bank_rdata [NUM_BANKS];
  logic                   mem_en;

  logic                   s2_wr_q;
  logic [REG_IDX_W-1:0]   s2_idx_q;
  logic [DATA_W-1:0]      s2_alu_q;
  load_e                  s2_ld_q;
  logic                   s2_st_q;
  logic [MEM_AW-1:0]      s2_addr_q;
  logic                   s2_bad_q;
  logic [DATA_W-1:0]      s2_val;
  logic [DATA_W-1:0]      ld_word;

  logic                   out_wr_q;
  logic [REG_IDX_W-1:0]   out_idx_q;
  logic [DATA_W-1:0]      out_val_q;
  logic                   out_st_q;
  logic [MEM_ADDR_OUT_W-1:0] out_addr_q;
  logic                   out_bad_q;

  assign out_free   = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || out_free;
  assign s2_adv     = s2_v_q && out_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (op_e'(req_type_i))
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_STW, OP_STB: begin
        in_p1 = reg_a_i;
      end
      default: begin
        in_p1 = reg_c_i;
      end
    endcase
  end

  assign p1_ra = in_p1[RF_AW-1:0];
  assign p2_ra = reg_b_i[RF_AW-1:0];
  assign rf_we = s2_adv && s2_wr_q;
  assign rf_wa = s2_idx_q[RF_AW-1:0];
  assign rf_wd = s2_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      rf_vld_q <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
    end
  end

  // Register file with write-first reads at request time.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (in_acc) begin
      if (!reg_in_range(in_p1)) begin
        rd1_q <= '0;
      end else if (rf_we && rf_wa == p1_ra) begin
        rd1_q <= rf_wd;
      end else if (!rf_vld_q[p1_ra]) begin
        rd1_q <= '0;
      end else begin
        rd1_q <= rf_mem[p1_ra];
      end
      if (!reg_in_range(reg_b_i)) begin
        rd2_q <= '0;
      end else if (rf_we && rf_wa == p2_ra) begin
        rd2_q <= rf_wd;
      end else if (!rf_vld_q[p2_ra]) begin
        rd2_q <= '0;
      end else begin
        rd2_q <= rf_mem[p2_ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= req_type_i;
      s1_a_q   <= reg_a_i;
      s1_c_q   <= reg_c_i;
      s1_p1_q  <= in_p1;
      s1_p2_q  <= reg_b_i;
      s1_imm_q <= immediate_i;
    end
  end

  // The instruction in the second stage has not yet written the register file.
  assign op1 = (s2_v_q && s2_wr_q && s2_idx_q == s1_p1_q) ? s2_val : rd1_q;
  assign op2 = (s2_v_q && s2_wr_q && s2_idx_q == s1_p2_q) ? s2_val : rd2_q;

  always_comb begin
    s1_wr   = 1'b0;
    s1_dst  = s1_a_q;
    s1_alu  = '0;
    s1_ld   = LD_NONE;
    s1_st   = 1'b0;
    s1_mem  = 1'b0;
    s1_word = 1'b0;
    s1_addr = '0;
    s1_bad  = 1'b0;
    unique case (op_e'(s1_op_q))
      OP_NOP: begin
      end
      OP_ADD: begin
        s1_wr  = 1'b1;
        s1_dst = s1_c_q;
        s1_alu = op1 + op2;
      end
      OP_SUB: begin
        s1_wr  = 1'b1;
        s1_dst = s1_c_q;
        s1_alu = op1 - op2;
      end
      OP_AND: begin
        s1_wr  = 1'b1;
        s1_dst = s1_c_q;
        s1_alu = op1 & op2;
      end
      OP_OR: begin
        s1_wr  = 1'b1;
        s1_dst = s1_c_q;
        s1_alu = op1 | op2;
      end
      OP_XOR: begin
        s1_wr  = 1'b1;
        s1_dst = s1_c_q;
        s1_alu = op1 ^ op2;
      end
      OP_NOT: begin
        s1_wr  = 1'b1;
        s1_alu = ~op2;
      end
      OP_LSH: begin
        s1_wr  = 1'b1;
        s1_alu = shift_val(op2, op1, 1'b0);
      end
      OP_ASH: begin
        s1_wr  = 1'b1;
        s1_alu = shift_val(op2, op1, 1'b1);
      end
      OP_TCU: begin
        s1_wr  = 1'b1;
        s1_alu = cmp3(op2, op1, 1'b0);
      end
      OP_TCS: begin
        s1_wr  = 1'b1;
        s1_alu = cmp3(op2, op1, 1'b1);
      end
      OP_SET: begin
        s1_wr  = 1'b1;
        s1_alu = DATA_W'(s1_imm_q);
      end
      OP_MOV: begin
        s1_wr  = 1'b1;
        s1_alu = op2;
      end
      OP_LDW: begin
        s1_wr   = 1'b1;
        s1_ld   = LD_WORD;
        s1_mem  = 1'b1;
        s1_word = 1'b1;
        s1_addr = op2[MEM_AW-1:0];
      end
      OP_STW: begin
        s1_st   = 1'b1;
        s1_mem  = 1'b1;
        s1_word = 1'b1;
        s1_addr = op1[MEM_AW-1:0];
      end
      OP_LDB: begin
        s1_wr   = 1'b1;
        s1_ld   = LD_BYTE;
        s1_mem  = 1'b1;
        s1_addr = op2[MEM_AW-1:0];
      end
      OP_STB: begin
        s1_st   = 1'b1;
        s1_mem  = 1'b1;
        s1_addr = op1[MEM_AW-1:0];
      end
      default: begin
        s1_bad = 1'b1;
      end
    endcase
    if (!s1_wr || !reg_in_range(s1_dst)) begin
      s1_wr  = 1'b0;
      s1_dst = '0;
      s1_alu = '0;
      s1_ld  = LD_NONE;
    end
  end

  // Byte i of a word access lands in bank (address + i) mod 4; banks below
  // the start bank take the next row.
  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    for (int k = 0; k < NUM_BANKS; k++) begin
      sel         = BANK_SEL_W'(k) - s1_addr[BANK_SEL_W-1:0];
      bank_row[k] = s1_addr[MEM_AW-1:BANK_SEL_W] +
                    ROW_W'(BANK_SEL_W'(k) < s1_addr[BANK_SEL_W-1:0]);
      bank_wd[k]  = op2[BYTE_W*sel +: BYTE_W];
      bank_we[k]  = s1_st && (s1_word || BANK_SEL_W'(k) == s1_addr[BANK_SEL_W-1:0]);
    end
  end

  assign mem_en = s1_adv && s1_mem;

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [BYTE_W-1:0] bank_mem [BANK_ROWS];
    logic [BYTE_W-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (mem_en) begin
        if (bank_we[g]) begin
          bank_mem[bank_row[g]] <= bank_wd[g];
        end
        rdata_q <= bank_mem[bank_row[g]];
      end
    end

    assign bank_rdata[g] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_wr_q   <= s1_wr;
      s2_idx_q  <= s1_dst;
      s2_alu_q  <= s1_alu;
      s2_ld_q   <= s1_ld;
      s2_st_q   <= s1_st;
      s2_addr_q <= s1_addr;
      s2_bad_q  <= s1_bad;
    end
  end

  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    for (int i = 0; i < NUM_BANKS; i++) begin
      sel                       = s2_addr_q[BANK_SEL_W-1:0] + BANK_SEL_W'(i);
      ld_word[BYTE_W*i +: BYTE_W] = bank_rdata[sel];
    end
    unique case (s2_ld_q)
      LD_WORD: s2_val = ld_word;
      LD_BYTE: s2_val = DATA_W'(bank_rdata[s2_addr_q[BANK_SEL_W-1:0]]);
      default: s2_val = s2_alu_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_wr_q   <= s2_wr_q;
      out_idx_q  <= s2_idx_q;
      out_val_q  <= s2_val;
      out_st_q   <= s2_st_q;
      out_addr_q <= MEM_ADDR_OUT_W'(s2_addr_q);
      out_bad_q  <= s2_bad_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign reg_written_o = out_wr_q;
  assign reg_index_o   = out_idx_q;
  assign reg_value_o   = out_val_q;
  assign mem_written_o = out_st_q;
  assign mem_address_o = out_addr_q;
  assign bad_opcode_o  = out_bad_q;

`ifndef SYNTH
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reg_written_o) |-> (reg_index_o == '0 && reg_value_o == '0))
    else $error("Result without a register write carries a nonzero index or value.");

  a_store_no_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mem_written_o) |-> !reg_written_o)
    else $error("Store result also reports a register write.");

  a_bad_is_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_opcode_o) |->
      (!reg_written_o && !mem_written_o && mem_address_o == '0))
    else $error("Illegal opcode had an effect.");

  a_rf_write_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |=> (out_v_q && out_wr_q))
    else $error("Register file write without a matching result.");
`endif

endmodule

`default_nettype wire
